@@ rtl/evs_pkg.sv @@
// Package for the energy VAD segmenter: configuration layout, register
// indexes, reset values and the per-sample state record.
// No dependencies.
package evs_pkg;

  // Field widths fixed by the interface
  localparam int SAMPLE_W    = 16;
  localparam int THRESH_W    = 16;
  localparam int CHUNK_W     = 16;
  localparam int RUN_W       = 8;
  localparam int MIN_SEG_W   = 22;
  localparam int POS_W       = 32;
  localparam int SUM_W       = 32;
  localparam int MAG_W       = 17;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;

  // Default saturation limit of the segment length counter
  localparam int MAX_SEGMENT_DEF = 2097152;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SPEECH_LEVEL      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SAMPLES     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_CHUNKS    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SEGMENT       = 8'd3;

  // Register reset values
  localparam logic [THRESH_W-1:0]  RST_SPEECH_LEVEL      = 16'd328;
  localparam logic [CHUNK_W-1:0]   RST_CHUNK_SAMPLES     = 16'd8000;
  localparam logic [RUN_W-1:0]     RST_SILENCE_CHUNKS    = 8'd2;
  localparam logic [MIN_SEG_W-1:0] RST_MIN_SEGMENT       = 22'd16000;

  localparam logic [RUN_W-1:0]     RUN_MAX = '1;

  typedef struct packed {
    logic [THRESH_W-1:0]  speech_level;
    logic [CHUNK_W-1:0]   chunk_samples;
    logic [RUN_W-1:0]     silence_chunks_to_close;
    logic [MIN_SEG_W-1:0] min_segment_samples;
  } cfg_t;

  // Stream state apart from the segment length, whose width follows a parameter
  typedef struct packed {
    logic             in_speech;
    logic [RUN_W-1:0] silent_run;
    logic [CHUNK_W-1:0] chunk_count;
    logic [SUM_W-1:0] level_sum;
    logic [POS_W-1:0] position;
  } stream_t;

endpackage

@@ rtl/evs_decide.sv @@
// Per-sample decision logic of the VAD segmenter: chunk energy test,
// hangover count, segment close and report. Purely combinational.
// Depends on evs_pkg.
module evs_decide import evs_pkg::*; #(
  parameter int MAX_SEGMENT = MAX_SEGMENT_DEF,
  parameter int SEG_W       = $clog2(MAX_SEGMENT + 1)
) (
  input  cfg_t                 cfg,
  input  stream_t              st,
  input  logic [SEG_W-1:0]     seg_len,
  input  logic [SAMPLE_W-1:0]  sample,
  input  logic                 stream_end,
  output stream_t              st_nxt,
  output logic [SEG_W-1:0]     seg_len_nxt,
  output logic                 emit,
  output logic                 emit_at_end,
  output logic [SEG_W-1:0]     emit_len,
  output logic [POS_W-1:0]     emit_pos
);

  localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(MAX_SEGMENT);

  logic [MAG_W-1:0]   mag;
  logic [SUM_W-1:0]   sum_inc;
  logic [CHUNK_W-1:0] count_inc;
  logic [SEG_W-1:0]   seg_inc;
  logic [POS_W-1:0]   pos_inc;
  logic [SUM_W-1:0]   need;
  logic               chunk_end;
  logic               speech;
  logic [RUN_W-1:0]   run_inc;
  logic               close;
  logic               long_enough;

  // Magnitude; the most negative sample gives 32768
  assign mag = sample[SAMPLE_W-1] ? (MAG_W'(17'h10000) - {1'b0, sample}) : {1'b0, sample};

  // Running counters for this sample
  assign sum_inc   = st.level_sum + SUM_W'(mag);
  assign count_inc = st.chunk_count + CHUNK_W'(1);
  assign seg_inc   = (seg_len < SEG_MAX) ? seg_len + SEG_W'(1) : seg_len;
  assign pos_inc   = st.position + POS_W'(1);

  // Speech test: sum of levels against threshold times samples in chunk
  assign need      = SUM_W'(cfg.speech_level) * SUM_W'(count_inc);
  assign chunk_end = (count_inc >= cfg.chunk_samples) || stream_end;
  assign speech    = sum_inc >= need;

  // Hangover: silent chunks after speech
  assign run_inc = (st.silent_run < RUN_MAX) ? st.silent_run + RUN_W'(1) : st.silent_run;
  assign close   = chunk_end && !speech && st.in_speech &&
                   (run_inc >= cfg.silence_chunks_to_close);

  assign long_enough = 32'(seg_inc) >= 32'(cfg.min_segment_samples);

  // Report: silence close first, end of stream only if nothing closed
  assign emit        = long_enough && (close || stream_end);
  assign emit_at_end = !close;
  assign emit_len    = seg_inc;
  assign emit_pos    = pos_inc;

  // Next state
  always_comb begin
    st_nxt      = st;
    seg_len_nxt = seg_inc;
    st_nxt.position    = pos_inc;
    st_nxt.chunk_count = count_inc;
    st_nxt.level_sum   = sum_inc;
    if (chunk_end) begin
      st_nxt.chunk_count = '0;
      st_nxt.level_sum   = '0;
      if (speech) begin
        st_nxt.in_speech  = 1'b1;
        st_nxt.silent_run = '0;
      end else if (st.in_speech) begin
        st_nxt.silent_run = run_inc;
        if (close) begin
          st_nxt.in_speech  = 1'b0;
          st_nxt.silent_run = '0;
          seg_len_nxt       = '0;
        end
      end
    end
    // End of recording returns every counter to reset
    if (stream_end) begin
      st_nxt      = '0;
      seg_len_nxt = '0;
    end
  end

endmodule

@@ rtl/energy_vad_segmenter.sv @@
// Energy-threshold VAD segmenter with hangover.
// A result word is registered: the sample word that closes the segment passes
// the input register, then the result register.
// Throughput: one sample word per cycle; the input stalls only while a report
// word waits on out_ready. Synchronous active-low reset restores register
// defaults and clears all stream state and both word valid flags.
module energy_vad_segmenter import evs_pkg::*; #(
  parameter int MAX_SEGMENT = MAX_SEGMENT_DEF,
  parameter int SEG_W       = $clog2(MAX_SEGMENT + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // sample words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                  in_stream_end,
  // segment reports
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SEG_W-1:0]      out_segment_samples,
  output logic [POS_W-1:0]      out_end_position,
  output logic                  out_at_stream_end
);

  cfg_t                cfg_r;
  stream_t             st_r, st_nxt;
  logic [SEG_W-1:0]    seg_len_r, seg_len_nxt;

  logic                in_full_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                stream_end_r;

  logic                out_valid_r;
  logic [SEG_W-1:0]    out_len_r;
  logic [POS_W-1:0]    out_pos_r;
  logic                out_end_r;

  logic                advance;
  logic                emit;
  logic                emit_at_end;
  logic [SEG_W-1:0]    emit_len;
  logic [POS_W-1:0]    emit_pos;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speech_level            <= RST_SPEECH_LEVEL;
      cfg_r.chunk_samples           <= RST_CHUNK_SAMPLES;
      cfg_r.silence_chunks_to_close <= RST_SILENCE_CHUNKS;
      cfg_r.min_segment_samples     <= RST_MIN_SEGMENT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SPEECH_LEVEL:      cfg_r.speech_level <= cfg_wdata[THRESH_W-1:0];
        REG_CHUNK_SAMPLES:     cfg_r.chunk_samples <= cfg_wdata[CHUNK_W-1:0];
        REG_SILENCE_CHUNKS:    cfg_r.silence_chunks_to_close <= cfg_wdata[RUN_W-1:0];
        REG_MIN_SEGMENT:       cfg_r.min_segment_samples <= cfg_wdata[MIN_SEG_W-1:0];
        default: ;
      endcase
    end
  end

  // The registered sample moves on unless a report is still waiting
  assign advance  = in_full_r && (!out_valid_r || out_ready);
  assign in_ready = !in_full_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_ready) begin
      in_full_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r     <= in_sample;
      stream_end_r <= in_stream_end;
    end
  end

  evs_decide #(
    .MAX_SEGMENT (MAX_SEGMENT),
    .SEG_W       (SEG_W)
  ) u_decide (
    .cfg         (cfg_r),
    .st          (st_r),
    .seg_len     (seg_len_r),
    .sample      (sample_r),
    .stream_end  (stream_end_r),
    .st_nxt      (st_nxt),
    .seg_len_nxt (seg_len_nxt),
    .emit        (emit),
    .emit_at_end (emit_at_end),
    .emit_len    (emit_len),
    .emit_pos    (emit_pos)
  );

  // Stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '0;
      seg_len_r <= '0;
    end else if (advance) begin
      st_r      <= st_nxt;
      seg_len_r <= seg_len_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_len_r <= emit_len;
      out_pos_r <= emit_pos;
      out_end_r <= emit_at_end;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_segment_samples = out_len_r;
  assign out_end_position    = out_pos_r;
  assign out_at_stream_end   = out_end_r;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for energy_vad_segmenter: directed corner cases and
// random speech/silence streams, each result word checked against a local model.
// Depends on evs_pkg and the energy_vad_segmenter RTL.
module tb_top;
  import evs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no accepted word before the run is abandoned; far above any
  // stall streak that the random idling can produce
  localparam int WATCHDOG_LIMIT = 2000;
  // settling time after the last report
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic [MIN_SEG_W-1:0] seg_len;
    logic [POS_W-1:0]     end_pos;
    logic                 at_end;
  } seg_report_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [SAMPLE_W-1:0]  in_sample = '0;
  logic                        in_stream_end = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [MIN_SEG_W-1:0]        out_segment_samples;
  logic [POS_W-1:0]            out_end_position;
  logic                        out_at_stream_end;

  // model copy of the registers
  logic [THRESH_W-1:0]  m_threshold;
  logic [CHUNK_W-1:0]   m_chunk_len;
  logic [RUN_W-1:0]     m_close_runs;
  logic [MIN_SEG_W-1:0] m_min_seg;
  // model copy of the stream state
  logic                 m_speaking;
  logic [RUN_W-1:0]     m_silent_run;
  logic [CHUNK_W-1:0]   m_chunk_cnt;
  logic [SUM_W-1:0]     m_level_acc;
  logic [MIN_SEG_W-1:0] m_seg_len;
  logic [POS_W-1:0]     m_pos;

  seg_report_t pending_reports[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  energy_vad_segmenter uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_sample           (in_sample),
    .in_stream_end       (in_stream_end),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_segment_samples (out_segment_samples),
    .out_end_position    (out_end_position),
    .out_at_stream_end   (out_at_stream_end)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- model
  task automatic clear_stream_state();
    m_speaking   = 1'b0;
    m_silent_run = '0;
    m_chunk_cnt  = '0;
    m_level_acc  = '0;
    m_seg_len    = '0;
    m_pos        = '0;
  endtask

  // Advance the segmenter model by one sample word; queue any report it makes
  task automatic advance_segmenter(input logic [SAMPLE_W-1:0] raw, input logic last);
    logic [MAG_W-1:0] mag;
    logic [63:0]      need;
    logic             closed;
    seg_report_t      rep;
    closed = 1'b0;
    mag = raw[SAMPLE_W-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    m_level_acc = m_level_acc + SUM_W'(mag);
    m_chunk_cnt = m_chunk_cnt + CHUNK_W'(1);
    if (m_seg_len < MAX_SEGMENT_DEF) m_seg_len = m_seg_len + MIN_SEG_W'(1);
    m_pos = m_pos + POS_W'(1);

    // chunk end: full chunk, or cut short by the end mark
    if (m_chunk_cnt >= m_chunk_len || last) begin
      need = 64'(m_threshold) * 64'(m_chunk_cnt);
      if (64'(m_level_acc) >= need) begin
        m_speaking   = 1'b1;
        m_silent_run = '0;
      end else if (m_speaking) begin
        if (m_silent_run < RUN_MAX) m_silent_run = m_silent_run + RUN_W'(1);
        if (m_silent_run >= m_close_runs) begin
          if (m_seg_len >= m_min_seg) begin
            rep.seg_len = m_seg_len;
            rep.end_pos = m_pos;
            rep.at_end  = 1'b0;
            pending_reports.push_back(rep);
          end
          m_seg_len    = '0;
          m_speaking   = 1'b0;
          m_silent_run = '0;
          closed       = 1'b1;
        end
      end
      m_chunk_cnt = '0;
      m_level_acc = '0;
    end

    // end of recording: report what is open unless silence just closed it
    if (last) begin
      if (!closed && m_seg_len >= m_min_seg) begin
        rep.seg_len = m_seg_len;
        rep.end_pos = m_pos;
        rep.at_end  = 1'b1;
        pending_reports.push_back(rep);
      end
      clear_stream_state();
    end
  endtask

  task automatic check_report(input seg_report_t got);
    seg_report_t want;
    if (pending_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected report word: len %0d end %0d at_end %0d",
                 got.seg_len, got.end_pos, got.at_end);
    end else begin
      want = pending_reports.pop_front();
      if (got.seg_len !== want.seg_len || got.end_pos !== want.end_pos ||
          got.at_end !== want.at_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"report mismatch: expected len %0d end %0d at_end %0d, ",
                    "got len %0d end %0d at_end %0d"},
                   want.seg_len, want.end_pos, want.at_end,
                   got.seg_len, got.end_pos, got.at_end);
      end
    end
  endtask

  // Watch all three channels: results first, then samples, then registers
  always @(posedge clk) begin
    if (!rst_n) begin
      m_threshold  = RST_SPEECH_LEVEL;
      m_chunk_len  = RST_CHUNK_SAMPLES;
      m_close_runs = RST_SILENCE_CHUNKS;
      m_min_seg    = RST_MIN_SEGMENT;
      clear_stream_state();
    end else begin
      if (out_valid && out_ready)
        check_report({out_segment_samples, out_end_position, out_at_stream_end});
      if (in_valid && in_ready)
        advance_segmenter(in_sample, in_stream_end);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPEECH_LEVEL:      m_threshold  = cfg_wdata[THRESH_W-1:0];
          REG_CHUNK_SAMPLES:     m_chunk_len  = cfg_wdata[CHUNK_W-1:0];
          REG_SILENCE_CHUNKS:    m_close_runs = cfg_wdata[RUN_W-1:0];
          REG_MIN_SEGMENT:       m_min_seg    = cfg_wdata[MIN_SEG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: abandon the run when no word moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("energy_vad_segmenter: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  // Send one sample word; valid stays high between back-to-back words
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_sample     <= s;
    in_stream_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold the sender until every queued report has arrived, then let it settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_config(input int thr, input int chunk, input int close_n, input int min_len);
    wait_idle();
    write_reg(REG_SPEECH_LEVEL, thr);
    write_reg(REG_CHUNK_SAMPLES, chunk);
    write_reg(REG_SILENCE_CHUNKS, close_n);
    write_reg(REG_MIN_SEGMENT, min_len);
    cfg_valid <= 1'b0;
  endtask

  // Sample of the given magnitude with a random sign; full scale is negative only
  function automatic logic signed [SAMPLE_W-1:0] level_sample(input int mag);
    if (mag >= 32768) return 16'h8000;
    if ($urandom_range(1)) return SAMPLE_W'(-mag);
    return SAMPLE_W'(mag);
  endfunction

  // ---------------------------------------------------------------- tests
  // Reset values: a short recording stays below the default minimum length
  task automatic test_reset_defaults();
    send_sample(16'sd20000, 1'b0);
    send_sample(-16'sd20000, 1'b0);
    send_sample(16'sd20000, 1'b1);
  endtask

  // Sample extremes; full negative scale is the only word that meets 32768
  task automatic test_level_extremes();
    apply_config(32768, 1, 1, 0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'h8000, 1'b1);
    // end mark on the very first word with no speech
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd1, 1'b1);
  endtask

  // Silence closes on the marked word: one report only, even with minimum 0
  task automatic test_close_on_last_sample();
    apply_config(32768, 1, 1, 0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'sd0, 1'b1);
  endtask

  // Zero chunk length and zero close count act as one
  task automatic test_zero_counts();
    apply_config(1000, 0, 0, 0);
    send_sample(16'sd5000, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd5000, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd5000, 1'b1);
  endtask

  // Zero threshold: every chunk is speech, closed only by the end mark
  task automatic test_threshold_zero();
    apply_config(0, 2, 1, 0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
  endtask

  // Largest chunk length and close count, with short recordings cut by the end mark
  task automatic test_register_maxima();
    apply_config(32768, 65535, 255, 2097152);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'sd12, 1'b1);
    apply_config(0, 65535, 255, 0);
    send_sample(16'sd7, 1'b0);
    send_sample(-16'sd7, 1'b1);
  endtask

  // One random setting: bursts of speech, silence and noise in recordings
  task automatic random_round(input int n_items);
    int thr, chunk, close_n, min_len;
    int sent, bursts, len, kind, mag;
    logic broken, is_last;
    logic signed [SAMPLE_W-1:0] s;
    thr     = ($urandom_range(5) == 0) ? 0 : $urandom_range(3000, 50);
    chunk   = $urandom_range(8, 1);
    close_n = $urandom_range(4, 1);
    min_len = $urandom_range(40, 0);
    apply_config(thr, chunk, close_n, min_len);
    sent = 0;
    while (sent < n_items) begin
      bursts = $urandom_range(6, 1);
      // now and then a recording runs on without its end mark
      broken = ($urandom_range(7) == 0);
      for (int b = 0; b < bursts && sent < n_items; b++) begin
        kind = $urandom_range(9);
        if (kind < 5)
          len = chunk * $urandom_range(3, 1) + $urandom_range(1);
        else
          len = chunk * $urandom_range(close_n + 1, 1);
        for (int k = 0; k < len && sent < n_items; k++) begin
          if (kind < 5) begin
            mag = $urandom_range(32768, thr);
            s = level_sample(mag);
          end else if (kind < 9) begin
            mag = (thr == 0) ? 0 : $urandom_range(thr - 1, 0);
            s = level_sample(mag);
          end else begin
            s = SAMPLE_W'($urandom);
          end
          is_last = !broken && (b == bursts - 1) && (k == len - 1);
          send_sample(s, is_last);
          sent++;
          // sender holds off once per round until the block has drained
          if (sent == n_items / 2) wait_idle();
        end
      end
    end
  endtask

  task automatic test_random_segments(input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    random_round(190);
    random_round(190);
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_level_extremes();
    test_close_on_last_sample();
    test_zero_counts();
    test_threshold_zero();
    test_register_maxima();

    test_random_segments(0, 0);
    test_random_segments(64, 0);
    test_random_segments(0, 64);
    test_random_segments(25, 25);

    wait_idle();
    if (mismatches == 0 && pending_reports.size() == 0)
      $display("energy_vad_segmenter: match");
    else
      $display("energy_vad_segmenter: mismatch");
    $finish;
  end

endmodule
